>>> rtl/core/quad_grid_cell_corners_defines.svh
// Assertion macros shared by the grid-cell corner RTL.
`ifndef QUAD_GRID_CELL_CORNERS_DEFINES_SVH
`define QUAD_GRID_CELL_CORNERS_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define QGCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qgcc same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define QGCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qgcc next-cycle check failed");

`endif

>>> rtl/core/qgcc_pkg.sv
// Shared types, widths and constants of the grid-cell corner block.
package qgcc_pkg;

    // Grid and interface sizes.
    localparam int GRID_SIZE_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int G_W             = 5;
    localparam int COORD_W         = 16;
    localparam int IDX_W           = 3;
    localparam int STEP_W          = 4;
    localparam int CFG_IDX_W       = 4;

    // Datapath widths, sized for the largest grid (16) and step (8).
    localparam int EDGE_W  = 21;
    localparam int LINE_W  = 22;
    localparam int CW      = 43;
    localparam int DET_W   = 44;
    localparam int SPLIT_W = 22;
    localparam int PL_W    = LINE_W + SPLIT_W + 1;
    localparam int PH_W    = LINE_W + CW - SPLIT_W;
    localparam int NUM_W   = 65;
    localparam int DEN_W   = 48;
    localparam int QBITS   = 15;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TL_X = 4'd0,
        REG_TL_Y = 4'd1,
        REG_TR_X = 4'd2,
        REG_TR_Y = 4'd3,
        REG_BR_X = 4'd4,
        REG_BR_Y = 4'd5,
        REG_BL_X = 4'd6,
        REG_BL_Y = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0] cell_column;
        logic [IDX_W-1:0] cell_row;
    } cell_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] top_left_x;
        logic signed [COORD_W-1:0] top_left_y;
        logic signed [COORD_W-1:0] top_right_x;
        logic signed [COORD_W-1:0] top_right_y;
        logic signed [COORD_W-1:0] bottom_left_x;
        logic signed [COORD_W-1:0] bottom_left_y;
        logic signed [COORD_W-1:0] bottom_right_x;
        logic signed [COORD_W-1:0] bottom_right_y;
        logic                      degenerate;
    } cell_corners_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] tl_x;
        logic signed [COORD_W-1:0] tl_y;
        logic signed [COORD_W-1:0] tr_x;
        logic signed [COORD_W-1:0] tr_y;
        logic signed [COORD_W-1:0] br_x;
        logic signed [COORD_W-1:0] br_y;
        logic signed [COORD_W-1:0] bl_x;
        logic signed [COORD_W-1:0] bl_y;
    } board_cfg_t;

    // Head of the request queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        cell_req_t req;
    } queue_head_t;

endpackage

>>> rtl/core/quad_grid_cell_corners.sv
// Top level of the grid-cell corner finder: configuration registers, queue and engine.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | cell_req_t (column, row)
//   m_      | out       | m_valid / m_ready  | cell_corners_t (four corners, flag)
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The engine works on a request one corner at a time, four corners in all; each
// corner ends in a bit-serial divide, which a corner with parallel lines skips.
// Reset is synchronous, active low; all corner registers reset to zero.
// Requests queue while the engine works; a finished result waits in the output
// register without blocking the next request from being computed.
module quad_grid_cell_corners #(
    parameter int GRID_SIZE   = qgcc_pkg::GRID_SIZE_DEF,
    parameter int QUEUE_DEPTH = qgcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qgcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qgcc_pkg::COORD_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  qgcc_pkg::cell_req_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output qgcc_pkg::cell_corners_t           m_data
);
    import qgcc_pkg::*;

    board_cfg_t  board_reg;
    queue_head_t head;
    logic        pop;

    assign cfg_ready = 1'b1;

    // Corner registers; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TL_X: board_reg.tl_x <= $signed(cfg_data);
                REG_TL_Y: board_reg.tl_y <= $signed(cfg_data);
                REG_TR_X: board_reg.tr_x <= $signed(cfg_data);
                REG_TR_Y: board_reg.tr_y <= $signed(cfg_data);
                REG_BR_X: board_reg.br_x <= $signed(cfg_data);
                REG_BR_Y: board_reg.br_y <= $signed(cfg_data);
                REG_BL_X: board_reg.bl_x <= $signed(cfg_data);
                REG_BL_Y: board_reg.bl_y <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Request queue.
    qgcc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .pop     (pop),
        .head    (head)
    );

    // Intersection engine and result register.
    qgcc_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .board   (board_reg),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/qgcc_front.sv
// Front end: accepts cell requests into a short queue for the back end.
`include "quad_grid_cell_corners_defines.svh"
module qgcc_front #(
    parameter int DEPTH = qgcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  qgcc_pkg::cell_req_t    s_data,
    input  logic                   pop,
    output qgcc_pkg::queue_head_t  head
);
    import qgcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_req_t        q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Handshake and head of queue.
    assign s_ready    = (count_reg < CNT_W'(DEPTH));
    assign push       = s_valid && s_ready;
    assign head.valid = (count_reg != '0);
    assign head.req   = q_mem[rd_ptr_reg];

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= s_data;
        end
    end

    `QGCC_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `QGCC_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0)

endmodule

>>> rtl/core/qgcc_div.sv
// Restoring divider with 16-bit saturation, one quotient bit per cycle.
`include "quad_grid_cell_corners_defines.svh"
module qgcc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [qgcc_pkg::NUM_W-1:0]         num_mag,
    input  logic [qgcc_pkg::DEN_W-1:0]         den_mag,
    input  logic                               neg,
    output logic                               done,
    output logic signed [qgcc_pkg::COORD_W-1:0] result
);
    import qgcc_pkg::*;

    localparam int CNT_W = $clog2(QBITS);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } div_state_t;

    div_state_t         state_reg;
    div_state_t         state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   dsh_reg;
    logic [QBITS-1:0]   q_reg;
    logic               sat_reg;
    logic               neg_reg;
    logic               ge;
    logic               load;
    logic signed [COORD_W-1:0] q_ext;

    assign ge   = (rem_reg >= dsh_reg);
    assign load = start && (state_reg == D_IDLE);
    assign done = (state_reg == D_DONE);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = D_DONE;
                end
            end
            D_DONE: begin
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                cnt_reg <= CNT_W'(QBITS - 1);
            end else if (state_reg == D_RUN) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Remainder, shifted divisor and quotient bits.
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= num_mag;
            dsh_reg <= NUM_W'(den_mag) << (QBITS - 1);
            sat_reg <= (num_mag >= (NUM_W'(den_mag) << QBITS));
            q_reg   <= '0;
            neg_reg <= neg;
        end else if (state_reg == D_RUN) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QBITS-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Sign and saturation of the truncated quotient.
    assign q_ext = $signed({1'b0, q_reg});
    always_comb begin
        if (sat_reg) begin
            result = neg_reg ? COORD_MIN : COORD_MAX;
        end else if (neg_reg) begin
            result = -q_ext;
        end else begin
            result = q_ext;
        end
    end

    `QGCC_ASSERT_NOW(a_start_idle, aclk, aresetn, start, state_reg == D_IDLE)
    `QGCC_ASSERT_NEXT(a_done_once, aclk, aresetn, state_reg == D_DONE, state_reg == D_IDLE)

endmodule

>>> rtl/core/qgcc_back.sv
// Back end: line intersections of the four cell corners and the result register.
`include "quad_grid_cell_corners_defines.svh"
module qgcc_back #(
    parameter int GRID_SIZE = qgcc_pkg::GRID_SIZE_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  qgcc_pkg::board_cfg_t     board,
    input  qgcc_pkg::queue_head_t    head,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output qgcc_pkg::cell_corners_t  m_data
);
    import qgcc_pkg::*;

    localparam logic signed [G_W:0] GRID_S = (G_W + 1)'(GRID_SIZE);

    typedef enum logic [10:0] {
        B_IDLE = 11'b000_0000_0001,
        B_EDGE = 11'b000_0000_0010,
        B_LINE = 11'b000_0000_0100,
        B_PROD = 11'b000_0000_1000,
        B_PART = 11'b000_0001_0000,
        B_TERM = 11'b000_0010_0000,
        B_DIFF = 11'b000_0100_0000,
        B_ABS  = 11'b000_1000_0000,
        B_DIV  = 11'b001_0000_0000,
        B_WAIT = 11'b010_0000_0000,
        B_OUT  = 11'b100_0000_0000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;
    logic [1:0]  corner_reg;
    logic [1:0]  corner_next;
    logic        degen_reg;
    logic        m_valid_reg;
    cell_corners_t m_data_reg;

    logic [IDX_W-1:0] col_reg;
    logic [IDX_W-1:0] row_reg;
    logic [STEP_W-1:0] k_step;
    logic [STEP_W-1:0] j_step;

    logic signed [EDGE_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [EDGE_W-1:0] cx_reg, cy_reg, dx_reg, dy_reg;
    logic signed [LINE_W-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [EDGE_W-1:0] lax_reg, lay_reg, lcx_reg, lcy_reg;
    logic signed [CW-1:0]     c1_reg, c2_reg;
    logic signed [DET_W-1:0]  det_reg;
    logic signed [PL_W-1:0]   pl_b2c1_reg, pl_b1c2_reg, pl_a1c2_reg, pl_a2c1_reg;
    logic signed [PH_W-1:0]   ph_b2c1_reg, ph_b1c2_reg, ph_a1c2_reg, ph_a2c1_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic                     det_zero_reg;
    logic signed [NUM_W-1:0]  t_b2c1_reg, t_b1c2_reg, t_a1c2_reg, t_a2c1_reg;
    logic signed [NUM_W-1:0]  numx_reg, numy_reg;
    logic [NUM_W-1:0]         magx_reg, magy_reg;
    logic [DEN_W-1:0]         dmag_reg;
    logic                     negx_reg, negy_reg;

    logic signed [COORD_W-1:0] res_x [4];
    logic signed [COORD_W-1:0] res_y [4];

    logic                      div_start;
    logic                      divx_done;
    logic                      divy_done;
    logic signed [COORD_W-1:0] divx_q;
    logic signed [COORD_W-1:0] divy_q;
    logic                      wr_corner;
    logic                      wr_zero;
    logic                      out_load;

    logic signed [CW-1:0]       c1_c, c2_c;
    logic signed [LINE_W+EDGE_W-1:0] p_a1ax, p_b1ay, p_a2cx, p_b2cy;
    logic signed [DET_W-1:0]    p_a1b2, p_a2b1;
    logic [SPLIT_W-1:0]         c1_lo, c2_lo;
    logic signed [CW-SPLIT_W-1:0] c1_hi, c2_hi;

    // One point on an edge, scaled by the grid size.
    function automatic logic signed [EDGE_W-1:0] edge_pt(
        input logic signed [COORD_W-1:0] from,
        input logic signed [COORD_W-1:0] to,
        input logic [STEP_W-1:0]         step
    );
        logic signed [COORD_W:0]  diff;
        logic signed [EDGE_W-1:0] base;
        logic signed [EDGE_W-1:0] span;
        diff = (COORD_W + 1)'(to) - (COORD_W + 1)'(from);
        base = EDGE_W'(from) * EDGE_W'(GRID_S);
        span = EDGE_W'(diff) * EDGE_W'($signed({1'b0, step}));
        return base + span;
    endfunction

    // Line indexes of the current corner.
    assign k_step = {1'b0, col_reg} + STEP_W'(corner_reg[0]);
    assign j_step = {1'b0, row_reg} + STEP_W'(corner_reg[1]);

    // Line constants and determinant products.
    assign p_a1ax = (LINE_W + EDGE_W)'(a1_reg) * (LINE_W + EDGE_W)'(lax_reg);
    assign p_b1ay = (LINE_W + EDGE_W)'(b1_reg) * (LINE_W + EDGE_W)'(lay_reg);
    assign p_a2cx = (LINE_W + EDGE_W)'(a2_reg) * (LINE_W + EDGE_W)'(lcx_reg);
    assign p_b2cy = (LINE_W + EDGE_W)'(b2_reg) * (LINE_W + EDGE_W)'(lcy_reg);
    assign p_a1b2 = DET_W'(a1_reg) * DET_W'(b2_reg);
    assign p_a2b1 = DET_W'(a2_reg) * DET_W'(b1_reg);
    assign c1_c   = CW'(p_a1ax) + CW'(p_b1ay);
    assign c2_c   = CW'(p_a2cx) + CW'(p_b2cy);

    // Split the line constants for the numerator partial products.
    assign c1_lo = c1_reg[SPLIT_W-1:0];
    assign c2_lo = c2_reg[SPLIT_W-1:0];
    assign c1_hi = c1_reg[CW-1:SPLIT_W];
    assign c2_hi = c2_reg[CW-1:SPLIT_W];

    // Sequencer over the four corners.
    always_comb begin
        state_next  = state_reg;
        corner_next = corner_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        wr_corner   = 1'b0;
        wr_zero     = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (head.valid) begin
                    pop         = 1'b1;
                    corner_next = 2'd0;
                    state_next  = B_EDGE;
                end
            end
            B_EDGE: state_next = B_LINE;
            B_LINE: state_next = B_PROD;
            B_PROD: state_next = B_PART;
            B_PART: state_next = B_TERM;
            B_TERM: state_next = B_DIFF;
            B_DIFF: state_next = B_ABS;
            B_ABS:  state_next = B_DIV;
            B_DIV: begin
                if (det_zero_reg) begin
                    wr_corner = 1'b1;
                    wr_zero   = 1'b1;
                end else begin
                    div_start  = 1'b1;
                    state_next = B_WAIT;
                end
            end
            B_WAIT: begin
                if (divx_done) begin
                    wr_corner = 1'b1;
                end
            end
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
        // Advance to the next corner once this one is stored.
        if (wr_corner) begin
            if (corner_reg == 2'd3) begin
                state_next = B_OUT;
            end else begin
                corner_next = corner_reg + 2'd1;
                state_next  = B_EDGE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            corner_reg  <= 2'd0;
            degen_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            if (pop) begin
                degen_reg <= 1'b0;
            end else if (wr_zero) begin
                degen_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic stages, one register set per step.
    always_ff @(posedge aclk) begin
        if (pop) begin
            col_reg <= head.req.cell_column;
            row_reg <= head.req.cell_row;
        end
        if (state_reg == B_EDGE) begin
            ax_reg <= edge_pt(board.tl_x, board.tr_x, k_step);
            ay_reg <= edge_pt(board.tl_y, board.tr_y, k_step);
            bx_reg <= edge_pt(board.bl_x, board.br_x, k_step);
            by_reg <= edge_pt(board.bl_y, board.br_y, k_step);
            cx_reg <= edge_pt(board.tl_x, board.bl_x, j_step);
            cy_reg <= edge_pt(board.tl_y, board.bl_y, j_step);
            dx_reg <= edge_pt(board.tr_x, board.br_x, j_step);
            dy_reg <= edge_pt(board.tr_y, board.br_y, j_step);
        end
        if (state_reg == B_LINE) begin
            a1_reg  <= LINE_W'(by_reg) - LINE_W'(ay_reg);
            b1_reg  <= LINE_W'(ax_reg) - LINE_W'(bx_reg);
            a2_reg  <= LINE_W'(dy_reg) - LINE_W'(cy_reg);
            b2_reg  <= LINE_W'(cx_reg) - LINE_W'(dx_reg);
            lax_reg <= ax_reg;
            lay_reg <= ay_reg;
            lcx_reg <= cx_reg;
            lcy_reg <= cy_reg;
        end
        if (state_reg == B_PROD) begin
            c1_reg  <= c1_c;
            c2_reg  <= c2_c;
            det_reg <= p_a1b2 - p_a2b1;
        end
        if (state_reg == B_PART) begin
            pl_b2c1_reg  <= PL_W'(b2_reg) * PL_W'($signed({1'b0, c1_lo}));
            pl_b1c2_reg  <= PL_W'(b1_reg) * PL_W'($signed({1'b0, c2_lo}));
            pl_a1c2_reg  <= PL_W'(a1_reg) * PL_W'($signed({1'b0, c2_lo}));
            pl_a2c1_reg  <= PL_W'(a2_reg) * PL_W'($signed({1'b0, c1_lo}));
            ph_b2c1_reg  <= PH_W'(b2_reg) * PH_W'(c1_hi);
            ph_b1c2_reg  <= PH_W'(b1_reg) * PH_W'(c2_hi);
            ph_a1c2_reg  <= PH_W'(a1_reg) * PH_W'(c2_hi);
            ph_a2c1_reg  <= PH_W'(a2_reg) * PH_W'(c1_hi);
            den_reg      <= DEN_W'(det_reg) * DEN_W'(GRID_S);
            det_zero_reg <= (det_reg == '0);
        end
        if (state_reg == B_TERM) begin
            t_b2c1_reg <= (NUM_W'(ph_b2c1_reg) <<< SPLIT_W) + NUM_W'(pl_b2c1_reg);
            t_b1c2_reg <= (NUM_W'(ph_b1c2_reg) <<< SPLIT_W) + NUM_W'(pl_b1c2_reg);
            t_a1c2_reg <= (NUM_W'(ph_a1c2_reg) <<< SPLIT_W) + NUM_W'(pl_a1c2_reg);
            t_a2c1_reg <= (NUM_W'(ph_a2c1_reg) <<< SPLIT_W) + NUM_W'(pl_a2c1_reg);
        end
        if (state_reg == B_DIFF) begin
            numx_reg <= t_b2c1_reg - t_b1c2_reg;
            numy_reg <= t_a1c2_reg - t_a2c1_reg;
        end
        if (state_reg == B_ABS) begin
            magx_reg <= numx_reg[NUM_W-1] ? NUM_W'(-numx_reg) : NUM_W'(numx_reg);
            magy_reg <= numy_reg[NUM_W-1] ? NUM_W'(-numy_reg) : NUM_W'(numy_reg);
            dmag_reg <= den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
            negx_reg <= numx_reg[NUM_W-1] ^ den_reg[DEN_W-1];
            negy_reg <= numy_reg[NUM_W-1] ^ den_reg[DEN_W-1];
        end
        if (wr_corner) begin
            res_x[corner_reg] <= wr_zero ? '0 : divx_q;
            res_y[corner_reg] <= wr_zero ? '0 : divy_q;
        end
        if (out_load) begin
            m_data_reg.top_left_x     <= res_x[0];
            m_data_reg.top_left_y     <= res_y[0];
            m_data_reg.top_right_x    <= res_x[1];
            m_data_reg.top_right_y    <= res_y[1];
            m_data_reg.bottom_left_x  <= res_x[2];
            m_data_reg.bottom_left_y  <= res_y[2];
            m_data_reg.bottom_right_x <= res_x[3];
            m_data_reg.bottom_right_y <= res_y[3];
            m_data_reg.degenerate     <= degen_reg;
        end
    end

    // Quotients for x and y run side by side.
    qgcc_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (magx_reg),
        .den_mag (dmag_reg),
        .neg     (negx_reg),
        .done    (divx_done),
        .result  (divx_q)
    );

    qgcc_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (magy_reg),
        .den_mag (dmag_reg),
        .neg     (negy_reg),
        .done    (divy_done),
        .result  (divy_q)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `QGCC_ASSERT_NOW(a_div_lockstep, aclk, aresetn, 1'b1, divx_done == divy_done)
    `QGCC_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        (state_reg == B_OUT) && m_valid_reg && !m_ready, state_reg == B_OUT)

endmodule
